FILE: design/byte_range_header_parser_core_assert.svh
// ---------------------------------------------------------------------------
// Range header parser assertion macros
// Concurrent assertion wrappers clocked on clk, with and without reset gating.
// ---------------------------------------------------------------------------
`ifndef BYTE_RANGE_HEADER_PARSER_CORE_ASSERT_SVH
`define BYTE_RANGE_HEADER_PARSER_CORE_ASSERT_SVH

// Check a property while out of reset.
`define BRHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define BRHP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/brhp_pkg.sv
// ---------------------------------------------------------------------------
// Range header parser package
// Shared codes, state records and the segment close function.
// ---------------------------------------------------------------------------
package brhp_pkg;

  // Parse phases
  localparam logic [2:0] PH_UNIT  = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_END   = 3'd2;
  localparam logic [2:0] PH_SKIP  = 3'd3;
  localparam logic [2:0] PH_ERROR = 3'd4;

  // Number sub-phases
  localparam logic [2:0] NS_EMPTY  = 3'd0;
  localparam logic [2:0] NS_WS     = 3'd1;
  localparam logic [2:0] NS_SIGN   = 3'd2;
  localparam logic [2:0] NS_DIGITS = 3'd3;
  localparam logic [2:0] NS_TRAIL  = 3'd4;
  localparam logic [2:0] NS_BAD    = 3'd5;

  // Start field kinds
  localparam logic [1:0] SK_EMPTY  = 2'd0;
  localparam logic [1:0] SK_SUFFIX = 2'd1;
  localparam logic [1:0] SK_VALUE  = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_RECORD = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_NO_EQ      = 3'd1;
  localparam logic [2:0] ERR_NO_DASH    = 3'd2;
  localparam logic [2:0] ERR_BAD_SUFFIX = 3'd3;
  localparam logic [2:0] ERR_BAD_NUMBER = 3'd4;
  localparam logic [2:0] ERR_ORDER      = 3'd5;

  // Characters
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  // Largest accumulator that may still take another digit
  localparam logic [63:0] ACC_GUARD = 64'd922337203685477580;

  // Number being parsed; magnitude reaches 2^63, hence 64 bits
  typedef struct packed {
    logic [2:0]  sub;
    logic        neg;
    logic [63:0] acc;
    logic        ovf;
  } brhp_num_t;

  // Parser state after one byte, handed to the close stage
  typedef struct packed {
    logic [2:0]  phase;
    logic [1:0]  kind;
    logic [62:0] saved;
    brhp_num_t   num;
    logic [2:0]  perr;
    logic        do_close;
    logic        fin;
  } brhp_snap_t;

  typedef struct packed {
    logic        rec;
    logic [2:0]  err;
    logic [62:0] start;
    logic [62:0] len;
  } brhp_close_t;

  // Result on its way to the output stage
  typedef struct packed {
    logic [1:0]  kind;
    logic        rec;
    logic [62:0] start;
    logic [62:0] len;
    logic [2:0]  err;
    logic        last;
  } brhp_res_t;

  function automatic logic num_ok(input brhp_num_t n);
    return (n.sub == NS_DIGITS || n.sub == NS_TRAIL) && !n.ovf && (n.neg || !n.acc[63]);
  endfunction

  // Close one segment: error code, or a (start, length) record
  function automatic brhp_close_t close_seg(input logic [2:0]  phase,
                                            input logic [1:0]  kind,
                                            input logic [62:0] saved,
                                            input brhp_num_t   num,
                                            input logic [62:0] size);
    brhp_close_t cl;
    logic [63:0] size_w;
    logic [63:0] saved_w;
    cl      = '0;
    size_w  = {1'b0, size};
    saved_w = {1'b0, saved};
    case (phase)
      PH_START: begin
        cl.err = ERR_NO_DASH;
      end
      PH_END: begin
        if (kind == SK_SUFFIX) begin
          if (num.sub == NS_EMPTY || num.neg) begin
            cl.err = ERR_BAD_SUFFIX;
          end else if (!num_ok(num)) begin
            cl.err = ERR_BAD_NUMBER;
          end else begin
            cl.rec = 1'b1;
            if (num.acc > size_w) begin
              cl.start = '0;
              cl.len   = size;
            end else begin
              cl.start = size - num.acc[62:0];
              cl.len   = num.acc[62:0];
            end
          end
        end else if (num.sub == NS_EMPTY) begin
          cl.rec   = 1'b1;
          cl.start = saved;
          cl.len   = size - saved;
        end else if (!num_ok(num)) begin
          cl.err = ERR_BAD_NUMBER;
        end else if ((num.neg && num.acc != '0) || saved_w > num.acc) begin
          cl.err = ERR_ORDER;
        end else begin
          cl.rec   = 1'b1;
          cl.start = saved;
          if (num.acc >= size_w) begin
            cl.len = size - saved;
          end else begin
            cl.len = num.acc[62:0] - saved + 63'd1;
          end
        end
      end
      default: begin
      end
    endcase
    return cl;
  endfunction

endpackage

FILE: design/byte_range_header_parser_core.sv
// ---------------------------------------------------------------------------
// Byte range header parser core
// Streams a Range header in byte by byte and emits (start, length) records.
// ---------------------------------------------------------------------------
// One header byte is taken per clock cycle unless the output stalls, and the
// result it causes reaches the output through its register stages: an input
// register, the parse state update, the segment close and the running total
// each own one register stage. in_tready follows out_tready combinationally,
// so the whole pipeline holds while a finished result waits to be taken.
// Bytes up to the first '=' are skipped; every ',' and the final byte close a
// segment. A record carries start and length clamped to resource_size; the
// final byte (in_tlast) always yields exactly one closing result: a record,
// an end marker, or the first parse error, after which the consumer should
// drop the records of that header. Write resource_size only while no header
// is in flight and the pipeline has drained.
module byte_range_header_parser_core (
  input  logic         clk,
  input  logic         rst_n,
  // Configuration: resource_size
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [62:0]  cfg_data,
  // Header bytes
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] header_byte
  input  logic         in_tlast,   // final_byte
  // Results
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,  // [62:0] range_start, [125:63] range_length,
                                   // [188:126] running_total, [191:189] error_code
  output logic [1:0]   out_tuser,  // [1:0] result_kind
  output logic         out_tlast   // last_result
);
  import brhp_pkg::*;

  logic [62:0] size_r;
  logic        advance;
  logic        snap_valid;
  brhp_snap_t  snap;
  logic        res_valid;
  brhp_res_t   res;
  brhp_res_t   out_res;
  logic [62:0] out_total;

  // Move every stage together whenever the output register is free
  assign advance   = !out_tvalid || out_tready;
  assign in_tready = advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
    end else if (cfg_valid) begin
      size_r <= cfg_data;
    end
  end

  // Byte parse and per-header state
  brhp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .in_valid   (in_tvalid),
    .in_byte    (in_tdata),
    .in_fin     (in_tlast),
    .size       (size_r),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  // Segment close: clamping and error checks
  brhp_closer u_closer (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .snap_valid (snap_valid),
    .snap       (snap),
    .size       (size_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Saturating total and output register
  brhp_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res),
    .out_valid (out_tvalid),
    .out_res   (out_res),
    .out_total (out_total)
  );

  assign out_tdata = {out_res.err, out_total, out_res.len, out_res.start};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule

FILE: design/brhp_parser.sv
// ---------------------------------------------------------------------------
// Range header parser front end
// Input register and per-byte parse state; emits a snapshot per byte.
// ---------------------------------------------------------------------------
module brhp_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  input  logic               in_fin,
  input  logic [62:0]        size,
  output logic               snap_valid,
  output brhp_pkg::brhp_snap_t snap
);
  import brhp_pkg::*;

  logic       in_valid_r;
  logic [7:0] byte_r;
  logic       fin_r;

  logic [2:0]  phase_r, phase_nxt;
  logic        segnz_r, segnz_nxt;
  brhp_num_t   num_r, num_nxt;
  logic [62:0] saved_r, saved_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [2:0]  perr_r, perr_nxt;

  logic        snap_valid_r;
  brhp_snap_t  snap_r, snap_nxt;

  logic [2:0]  p1;
  logic        seg1;
  brhp_num_t   num1;
  logic [62:0] saved1;
  logic [1:0]  kind1;
  logic [2:0]  perr1;
  logic        do_close;
  logic [2:0]  comma_err;

  function automatic brhp_num_t feed_num(input brhp_num_t n, input logic [7:0] c);
    brhp_num_t  r;
    logic       dig;
    logic       ws;
    logic [3:0] d;
    r   = n;
    dig = (c >= CH_0) && (c <= CH_9);
    ws  = (c >= CH_TAB) && (c <= CH_CR);
    d   = c[3:0];
    case (n.sub)
      NS_EMPTY, NS_WS: begin
        if (c != CH_SP) begin
          if (ws) begin
            r.sub = NS_WS;
          end else if (c == CH_PLUS || c == CH_DASH) begin
            r.neg = (c == CH_DASH);
            r.sub = NS_SIGN;
          end else if (dig) begin
            r.acc = {60'd0, d};
            r.sub = NS_DIGITS;
          end else begin
            r.sub = NS_BAD;
          end
        end
      end
      NS_SIGN: begin
        if (dig) begin
          r.acc = {60'd0, d};
          r.sub = NS_DIGITS;
        end else begin
          r.sub = NS_BAD;
        end
      end
      NS_DIGITS: begin
        if (dig) begin
          if (n.ovf || n.acc > ACC_GUARD || (n.acc == ACC_GUARD && d > 4'd8)) begin
            r.ovf = 1'b1;
          end else begin
            r.acc = (n.acc << 3) + (n.acc << 1) + {60'd0, d};
          end
        end else if (c == CH_SP) begin
          r.sub = NS_TRAIL;
        end else begin
          r.sub = NS_BAD;
        end
      end
      NS_TRAIL: begin
        if (c != CH_SP) begin
          r.sub = NS_BAD;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // A comma closes the segment held in the registers; only its error matters here
  assign comma_err = close_seg(phase_r, kind_r, saved_r, num_r, size).err;

  always_comb begin
    p1     = phase_r;
    seg1   = segnz_r;
    num1   = num_r;
    saved1 = saved_r;
    kind1  = kind_r;
    perr1  = perr_r;
    if (phase_r == PH_UNIT) begin
      if (byte_r == CH_EQ) begin
        p1     = PH_START;
        seg1   = 1'b0;
        num1   = '0;
        saved1 = '0;
        kind1  = SK_EMPTY;
      end
    end else if (phase_r != PH_ERROR && byte_r != CH_COMMA) begin
      seg1 = 1'b1;
      if (phase_r == PH_START) begin
        if (byte_r == CH_DASH) begin
          if (num_r.sub == NS_EMPTY) begin
            kind1 = SK_SUFFIX;
            p1    = PH_END;
            num1  = '0;
          end else if (!num_ok(num_r)) begin
            p1    = PH_ERROR;
            perr1 = ERR_BAD_NUMBER;
          end else if (num_r.acc >= {1'b0, size}) begin
            p1   = PH_SKIP;
            num1 = '0;
          end else begin
            saved1 = num_r.acc[62:0];
            kind1  = SK_VALUE;
            p1     = PH_END;
            num1   = '0;
          end
        end else begin
          num1 = feed_num(num_r, byte_r);
        end
      end else if (phase_r == PH_END) begin
        num1 = feed_num(num_r, byte_r);
      end
    end

    do_close = (p1 == PH_START || p1 == PH_END || p1 == PH_SKIP) &&
               (byte_r == CH_COMMA || (fin_r && seg1));

    phase_nxt = p1;
    segnz_nxt = seg1;
    num_nxt   = num1;
    saved_nxt = saved1;
    kind_nxt  = kind1;
    perr_nxt  = perr1;
    if (fin_r) begin
      // back to reset values for the next header
      phase_nxt = PH_UNIT;
      segnz_nxt = 1'b0;
      num_nxt   = '0;
      saved_nxt = '0;
      kind_nxt  = SK_EMPTY;
      perr_nxt  = ERR_NONE;
    end else if (do_close) begin
      if (comma_err != ERR_NONE) begin
        phase_nxt = PH_ERROR;
        perr_nxt  = comma_err;
      end else begin
        phase_nxt = PH_START;
        segnz_nxt = 1'b0;
        num_nxt   = '0;
        saved_nxt = '0;
        kind_nxt  = SK_EMPTY;
      end
    end

    snap_nxt.phase    = p1;
    snap_nxt.kind     = kind1;
    snap_nxt.saved    = saved1;
    snap_nxt.num      = num1;
    snap_nxt.perr     = perr1;
    snap_nxt.do_close = do_close;
    snap_nxt.fin      = fin_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      snap_valid_r <= 1'b0;
      phase_r      <= PH_UNIT;
      segnz_r      <= 1'b0;
      num_r        <= '0;
      saved_r      <= '0;
      kind_r       <= SK_EMPTY;
      perr_r       <= ERR_NONE;
    end else if (advance) begin
      in_valid_r   <= in_valid;
      snap_valid_r <= in_valid_r;
      if (in_valid_r) begin
        phase_r <= phase_nxt;
        segnz_r <= segnz_nxt;
        num_r   <= num_nxt;
        saved_r <= saved_nxt;
        kind_r  <= kind_nxt;
        perr_r  <= perr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (in_valid) begin
        byte_r <= in_byte;
        fin_r  <= in_fin;
      end
      snap_r <= snap_nxt;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule

FILE: design/brhp_closer.sv
// ---------------------------------------------------------------------------
// Range header parser segment close
// Turns a byte snapshot into a record, end marker or error result.
// ---------------------------------------------------------------------------
module brhp_closer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  logic                 snap_valid,
  input  brhp_pkg::brhp_snap_t snap,
  input  logic [62:0]          size,
  output logic                 res_valid,
  output brhp_pkg::brhp_res_t  res
);
  import brhp_pkg::*;

  brhp_close_t cl;
  brhp_res_t   res_nxt;
  logic        has_out;
  logic        res_valid_r;
  brhp_res_t   res_r;

  assign cl = close_seg(snap.phase, snap.kind, snap.saved, snap.num, size);

  always_comb begin
    res_nxt      = '0;
    res_nxt.last = snap.fin;
    has_out      = 1'b0;
    if (snap.fin) begin
      has_out = 1'b1;
      if (snap.phase == PH_UNIT) begin
        res_nxt.kind = KIND_ERROR;
        res_nxt.err  = ERR_NO_EQ;
      end else if (snap.phase == PH_ERROR) begin
        res_nxt.kind = KIND_ERROR;
        res_nxt.err  = snap.perr;
      end else if (snap.do_close && cl.err != ERR_NONE) begin
        res_nxt.kind = KIND_ERROR;
        res_nxt.err  = cl.err;
      end else if (snap.do_close && cl.rec) begin
        res_nxt.kind  = KIND_RECORD;
        res_nxt.rec   = 1'b1;
        res_nxt.start = cl.start;
        res_nxt.len   = cl.len;
      end else begin
        res_nxt.kind = KIND_END;
      end
    end else if (snap.do_close && cl.rec) begin
      has_out       = 1'b1;
      res_nxt.kind  = KIND_RECORD;
      res_nxt.rec   = 1'b1;
      res_nxt.start = cl.start;
      res_nxt.len   = cl.len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= snap_valid && has_out;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

FILE: design/brhp_accum.sv
// ---------------------------------------------------------------------------
// Range header parser running total and output register
// Adds record lengths with saturation and holds the result for the consumer.
// ---------------------------------------------------------------------------
module brhp_accum (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic                res_valid,
  input  brhp_pkg::brhp_res_t res,
  output logic                out_valid,
  output brhp_pkg::brhp_res_t out_res,
  output logic [62:0]         out_total
);
  import brhp_pkg::*;

  logic [62:0] total_r, total_nxt;
  logic [63:0] sum;
  logic [62:0] total_new;
  logic        out_valid_r;
  brhp_res_t   out_res_r;
  logic [62:0] out_total_r;

  assign sum       = {1'b0, total_r} + {1'b0, res.len};
  assign total_new = res.rec ? (sum[63] ? '1 : sum[62:0]) : total_r;
  assign total_nxt = res.last ? '0 : total_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else if (advance) begin
      out_valid_r <= res_valid;
      if (res_valid) begin
        total_r <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res_r   <= res;
      out_total_r <= (res.kind == KIND_ERROR) ? '0 : total_new;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_total = out_total_r;

endmodule

FILE: design/brhp_checker.sv
// ---------------------------------------------------------------------------
// Range header parser port checker
// Watches the result channel of the core and is bound to the top level.
// ---------------------------------------------------------------------------
`include "byte_range_header_parser_core_assert.svh"

module brhp_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [191:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);
  import brhp_pkg::*;

  // An error closes the header and carries no record or total
  `BRHP_ASSERT(a_err_clean, out_tvalid && out_tuser == KIND_ERROR |-> out_tlast && out_tdata[188:0] == '0, "error result not clean")
  // An end marker closes the header and carries no record or error
  `BRHP_ASSERT(a_end_clean, out_tvalid && out_tuser == KIND_END |-> out_tlast && out_tdata[125:0] == '0 && out_tdata[191:189] == ERR_NONE, "end result not clean")
  // Records never carry an error code
  `BRHP_ASSERT(a_rec_code, out_tvalid && out_tuser == KIND_RECORD |-> out_tdata[191:189] == ERR_NONE, "record with error code")
  // Hold a stalled result
  `BRHP_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result changed")
  // Drop any result while in reset
  `BRHP_ASSERT_RST(a_rst_idle, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind byte_range_header_parser_core brhp_checker u_brhp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
